>>> rtl/core/sfdm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sensor frame demultiplexer.
// No dependencies; used by every module in rtl/core.

package sfdm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SENSOR_W   = 15;
	localparam int DIGITAL_W  = 16;
	localparam int VERSION_W  = 15;
	localparam int MAJOR_W    = 7;
	localparam int MINOR_W    = 8;
	localparam int NUM_SENSOR = 8;
	localparam int CNT_W      = 4;

	// slot counter codes
	localparam logic [CNT_W-1:0] SLOT_VERSION = 4'd0;
	localparam logic [CNT_W-1:0] SLOT_DIGITAL = 4'd9;

	// held values of one frame, as shown on the result channel
	typedef struct packed {
		logic [NUM_SENSOR-1:0][SENSOR_W-1:0] sensor;
		logic [DIGITAL_W-1:0]                digital;
		logic [VERSION_W-1:0]                version;
	} result_t;

endpackage

>>> rtl/core/sensor_frame_demultiplexer_unit.sv
`timescale 1ns / 1ps
// Sensor frame demultiplexer: one stream word in, one snapshot of held slots out.
// Depends on sfdm_pkg, sfdm_slot_tracker, sfdm_out_skid.
//
// Usage:
//   Input channel: sample with in_valid / in_stall. Each accepted word advances
//   the slot counter: a negative word (or any word after a full frame) starts
//   a frame; then slot 0 is the hardware version, slots 1-8 analog sensors,
//   slot 9 the digital word. A negative word just before a start flag is taken
//   as the digital word.
//   Output channel: out_valid / out_stall with sensor_1..sensor_8,
//   digital_word, hw_ver_major, hw_ver_minor, connected. Exactly one result
//   per accepted word, in order.
//   Each result is registered, in the output register or the skid entry.
//   Throughput: one word per cycle while in_stall is low; the slot update is a
//   compare and a register write between the input port and the output register.
//   Stall: the output register plus one skid entry hold results; in_stall rises
//   only once both are full, i.e. once a word is accepted during a receiver
//   stall with a result already waiting.
//   Reset (arst_n low): counter, held slots and version clear to zero; no
//   results pending.

module sensor_frame_demultiplexer_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [sfdm_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_1,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_2,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_3,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_4,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_5,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_6,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_7,
	output logic [sfdm_pkg::SENSOR_W-1:0]         sensor_8,
	output logic [sfdm_pkg::DIGITAL_W-1:0]        digital_word,
	output logic [sfdm_pkg::MAJOR_W-1:0]          hw_ver_major,
	output logic [sfdm_pkg::MINOR_W-1:0]          hw_ver_minor,
	output logic                                  connected
);

	logic              accept;
	logic              skid_full;
	sfdm_pkg::result_t next_result;
	sfdm_pkg::result_t shown;

	assign in_stall = skid_full;
	assign accept   = in_valid && !skid_full;

	sfdm_slot_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.result (next_result)
	);

	sfdm_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (next_result),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (shown)
	);

	assign sensor_1      = shown.sensor[0];
	assign sensor_2      = shown.sensor[1];
	assign sensor_3      = shown.sensor[2];
	assign sensor_4      = shown.sensor[3];
	assign sensor_5      = shown.sensor[4];
	assign sensor_6      = shown.sensor[5];
	assign sensor_7      = shown.sensor[6];
	assign sensor_8      = shown.sensor[7];
	assign digital_word  = shown.digital;
	assign hw_ver_major  = shown.version[sfdm_pkg::VERSION_W-1:sfdm_pkg::MINOR_W];
	assign hw_ver_minor  = shown.version[sfdm_pkg::MINOR_W-1:0];
	assign connected     = |shown.version;

endmodule

>>> rtl/core/sfdm_slot_tracker.sv
`timescale 1ns / 1ps
// Slot counter and held slot values; updates on every accepted word.
// Depends on sfdm_pkg.

module sfdm_slot_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic signed [sfdm_pkg::SAMPLE_W-1:0] sample,
	output sfdm_pkg::result_t               result
);

	logic [sfdm_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [sfdm_pkg::SAMPLE_W-1:0] prev_q;
	sfdm_pkg::result_t             held_q, held_d;
	logic                          start;

	// negative word, or anything after a full frame, restarts the frame
	assign start = sample[sfdm_pkg::SAMPLE_W-1] || (cnt_q > sfdm_pkg::SLOT_DIGITAL);

	always_comb begin
		cnt_d  = cnt_q;
		held_d = held_q;
		if (start) begin
			// a negative word before the flag was the digital word
			if (prev_q[sfdm_pkg::SAMPLE_W-1]) begin
				held_d.digital = prev_q;
			end
			cnt_d = sfdm_pkg::SLOT_VERSION;
		end else if (cnt_q == sfdm_pkg::SLOT_VERSION) begin
			held_d.version = sample[sfdm_pkg::VERSION_W-1:0];
			cnt_d          = cnt_q + 1'b1;
		end else begin
			if (cnt_q == sfdm_pkg::SLOT_DIGITAL) begin
				held_d.digital = sample;
			end
			for (int i = 0; i < sfdm_pkg::NUM_SENSOR; i++) begin
				if (cnt_q == sfdm_pkg::CNT_W'(i + 1)) begin
					held_d.sensor[i] = sample[sfdm_pkg::SENSOR_W-1:0];
				end
			end
			cnt_d = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			prev_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			cnt_q  <= cnt_d;
			prev_q <= sample;
			held_q <= held_d;
		end
	end

	assign result = held_d;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sfdm_pkg::SLOT_DIGITAL + 1'b1)
		else $error("slot counter past end of frame");
	a_flag_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sample[sfdm_pkg::SAMPLE_W-1] |=> cnt_q == sfdm_pkg::SLOT_VERSION)
		else $error("start flag did not rewind slot counter");
`endif

endmodule

>>> rtl/core/sfdm_out_skid.sv
`timescale 1ns / 1ps
// Output register plus one skid entry for the result channel.
// Depends on sfdm_pkg.

module sfdm_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfdm_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output sfdm_pkg::result_t out_data
);

	sfdm_pkg::result_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              load;

	assign load = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	// push is only offered while the skid entry is empty
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_valid_q && out_stall |=> skid_valid_q)
		else $error("word lost while output stalled");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> !skid_valid_q && out_valid_q)
		else $error("skid entry not drained");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("push into full skid entry");
`endif

endmodule
